>>> rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_EVENT = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [3:0] EV_START      = 4'd0;
  localparam logic [3:0] EV_REP_START  = 4'd1;
  localparam logic [3:0] EV_SLAW_ACK   = 4'd2;
  localparam logic [3:0] EV_TX_ACK     = 4'd3;
  localparam logic [3:0] EV_RX_ACK     = 4'd4;
  localparam logic [3:0] EV_SLAR_ACK   = 4'd5;
  localparam logic [3:0] EV_RX_NACK    = 4'd6;
  localparam logic [3:0] EV_ARB_LOST   = 4'd7;
  localparam logic [3:0] EV_OTHER      = 4'd12;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_SUCCESS = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [5:0] POS_MAX = 6'd63;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] buf_index;
    logic [7:0] buf_data;
    logic [5:0] msg_size;
    logic [3:0] bus_event;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_load;
    logic       drive_start;
    logic       drive_stop;
    logic       ack_enable;
    logic       busy_res;
    logic [1:0] xfer_status;
    logic [3:0] error_event;
    logic [7:0] read_data;
  } rsp_t;

  // result control that travels alongside the buffer read
  typedef struct packed {
    logic       tx_load;
    logic       drive_start;
    logic       drive_stop;
    logic       ack_enable;
    logic       busy_res;
    logic [1:0] xfer_status;
    logic [3:0] error_event;
    logic       rd_sel;
  } ctl_t;

endpackage

>>> rtl/i2cms_buf.sv
// ----------------------------------------------------------------------------
// i2cms_buf
// Message buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cms_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/i2cms_ctrl.sv
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Transfer state and per-beat decision logic; drives the buffer ports.
// ----------------------------------------------------------------------------
module i2cms_ctrl import i2cms_pkg::*; #(
  parameter int BUF_DEPTH = 32,
  parameter int AW        = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  req_t          req,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic [AW-1:0] raddr,
  output ctl_t          ctl
);

  localparam logic [8:0] DEPTH9 = 9'(BUF_DEPTH);

  logic [5:0] msg_length, msg_length_next;
  logic [5:0] byte_pos, byte_pos_next;
  logic [1:0] status_reg, status_reg_next;
  logic [3:0] last_error, last_error_next;
  logic       busy_flag, busy_flag_next;

  logic [8:0] idx_ext;
  logic       idx_ok;
  logic [5:0] pos_eff;
  logic [8:0] pos_ext;
  logic [8:0] pos_eff_ext;
  logic       pos_ok;
  logic [5:0] pos_inc;
  logic [5:0] pos_inc_eff;

  always_comb begin
    idx_ext     = {4'b0, req.buf_index};
    idx_ok      = idx_ext < DEPTH9;
    pos_ext     = {3'b0, byte_pos};
    pos_ok      = pos_ext < DEPTH9;
    pos_inc     = (byte_pos == POS_MAX) ? POS_MAX : byte_pos + 6'd1;
    pos_eff     = (req.bus_event == EV_START || req.bus_event == EV_REP_START) ?
                  6'd0 : byte_pos;
    pos_eff_ext = {3'b0, pos_eff};
    pos_inc_eff = (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 6'd1;

    msg_length_next = msg_length;
    byte_pos_next   = byte_pos;
    status_reg_next = status_reg;
    last_error_next = last_error;
    busy_flag_next  = busy_flag;

    we    = 1'b0;
    waddr = idx_ext[AW-1:0];
    wdata = req.buf_data;
    raddr = idx_ext[AW-1:0];
    ctl   = '0;

    case (req.req_type)
      REQ_LOAD: begin
        we = idx_ok;
      end
      REQ_START: begin
        if (!busy_flag) begin
          msg_length_next = ({3'b0, req.msg_size} > DEPTH9) ? DEPTH9[5:0] : req.msg_size;
          status_reg_next = ST_NONE;
          busy_flag_next  = 1'b1;
          ctl.drive_start = 1'b1;
        end
      end
      REQ_READ: begin
        ctl.rd_sel = idx_ok;
      end
      default: begin
        if (busy_flag) begin
          case (req.bus_event)
            EV_START, EV_REP_START, EV_SLAW_ACK, EV_TX_ACK: begin
              byte_pos_next = pos_eff;
              if (pos_eff < msg_length) begin
                raddr         = pos_eff_ext[AW-1:0];
                ctl.tx_load   = 1'b1;
                byte_pos_next = pos_inc_eff;
              end else begin
                status_reg_next = ST_SUCCESS;
                ctl.drive_stop  = 1'b1;
                busy_flag_next  = 1'b0;
              end
            end
            EV_RX_ACK: begin
              we             = pos_ok;
              waddr          = pos_ext[AW-1:0];
              wdata          = req.rx_byte;
              byte_pos_next  = pos_inc;
              ctl.ack_enable = ({1'b0, pos_inc} + 7'd1) < {1'b0, msg_length};
            end
            EV_SLAR_ACK: begin
              ctl.ack_enable = ({1'b0, byte_pos} + 7'd1) < {1'b0, msg_length};
            end
            EV_RX_NACK: begin
              we              = pos_ok;
              waddr           = pos_ext[AW-1:0];
              wdata           = req.rx_byte;
              status_reg_next = ST_SUCCESS;
              ctl.drive_stop  = 1'b1;
              busy_flag_next  = 1'b0;
            end
            EV_ARB_LOST: begin
              ctl.drive_start = 1'b1;
            end
            default: begin
              status_reg_next = ST_ERROR;
              last_error_next = (req.bus_event > EV_OTHER) ? EV_OTHER : req.bus_event;
              busy_flag_next  = 1'b0;
            end
          endcase
        end
      end
    endcase

    we              = we & fire;
    ctl.busy_res    = busy_flag_next;
    ctl.xfer_status = status_reg_next;
    ctl.error_event = last_error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_length <= '0;
      byte_pos   <= '0;
      status_reg <= ST_NONE;
      last_error <= '0;
      busy_flag  <= 1'b0;
    end else if (fire) begin
      msg_length <= msg_length_next;
      byte_pos   <= byte_pos_next;
      status_reg <= status_reg_next;
      last_error <= last_error_next;
      busy_flag  <= busy_flag_next;
    end
  end

endmodule

>>> rtl/i2cms_out.sv
// ----------------------------------------------------------------------------
// i2cms_out
// Read-data stage and result register; merges buffer data into the result.
// ----------------------------------------------------------------------------
module i2cms_out import i2cms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  ctl_t       ctl,
  input  logic [7:0] rdata,
  output logic       in_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp
);

  logic s1_valid;
  ctl_t s1_ctl;
  logic s1_move;
  rsp_t rsp_next;

  assign s1_move  = s1_valid && (!rsp_valid || !rsp_stall);
  assign in_stall = s1_valid && !s1_move;

  always_comb begin
    rsp_next.tx_byte     = s1_ctl.tx_load ? rdata : 8'd0;
    rsp_next.tx_load     = s1_ctl.tx_load;
    rsp_next.drive_start = s1_ctl.drive_start;
    rsp_next.drive_stop  = s1_ctl.drive_stop;
    rsp_next.ack_enable  = s1_ctl.ack_enable;
    rsp_next.busy_res    = s1_ctl.busy_res;
    rsp_next.xfer_status = s1_ctl.xfer_status;
    rsp_next.error_event = s1_ctl.error_event;
    rsp_next.read_data   = s1_ctl.rd_sel ? rdata : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_ctl <= ctl;
    end
    if (s1_move) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/i2c_master_transaction_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top
// Sequences an I2C master transfer from a message buffer, one request per beat.
// ----------------------------------------------------------------------------
// A request beat loads a buffer byte, starts a transfer, reports a bus event
// or reads a buffer byte; every request returns exactly one result beat. One
// request is taken per clock while req_stall is low: the transfer state sits
// in flops and is decided in the accept cycle, the buffer RAM is written or
// read at that same edge, and its registered read data is merged into the
// result register when the read stage moves on. A read stage plus the result
// register let a new request enter while a finished result still waits.
// Buffer entries never loaded read back as undefined data.
module i2c_master_transaction_sequencer_top import i2cms_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic          fire;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  ctl_t          ctl;

  assign fire = req_valid && !req_stall;

  i2cms_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .req   (req),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .ctl   (ctl)
  );

  i2cms_buf #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (fire),
    .raddr (raddr),
    .rdata (rdata)
  );

  i2cms_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ctl       (ctl),
    .rdata     (rdata),
    .in_stall  (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
